// ----- rtl/spe_pkg.sv -----
// Shared types, constants and elaboration-time table functions for the position encoder.
package spe_pkg;

    localparam int DIM_DEFAULT          = 128;
    localparam int CORDIC_STEPS_DEFAULT = 16;

    localparam int POS_W   = 12;
    localparam int PAIR_W  = 6;
    localparam int VAL_W   = 16;
    localparam int RESID_W = 30;
    // CORDIC datapath width: Q30 values plus sign and headroom
    localparam int CW      = 33;

    localparam logic [63:0] LOG2_TENK_Q32  = 64'd57070290109;
    localparam logic [63:0] LN2_Q32        = 64'd2977044472;
    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [PAIR_W-1:0] pair_index;
    } in_beat_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sin_value;
        logic signed [VAL_W-1:0] cos_value;
    } out_beat_t;

    typedef struct packed {
        logic               blank;
        quad_t              quad;
        logic [RESID_W-1:0] resid;
    } phase_beat_t;

    typedef struct packed {
        logic                 blank;
        quad_t                quad;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_beat_t;

    // Pair frequency in turns per position (UQ0.32) from the Q32 exponent 2i*log2(1e4)/DIM
    function automatic logic [31:0] pair_frequency(input logic [63:0] exp_q32);
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] term;
        logic [63:0] pos_sum;
        logic [63:0] neg_sum;
        logic [63:0] m;
        logic [63:0] prod;
        int          sh;
        sh      = 32 + int'(exp_q32 >> 32);
        u       = {32'd0, exp_q32[31:0]};
        v       = (u * LN2_Q32) >> 32;
        term    = 64'd1 << 32;
        pos_sum = term;
        neg_sum = 64'd0;
        // exp(-v) by Taylor series, odd terms subtract
        for (int n = 1; n <= 20; n++) begin
            term = ((term * v) >> 32) / 64'(n);
            if ((n & 1) != 0) neg_sum = neg_sum + term;
            else              pos_sum = pos_sum + term;
        end
        m = pos_sum - neg_sum;
        if (sh >= 63) return 32'd0;
        prod = (m * INV_TWO_PI_Q32 + (64'd1 << (sh - 1))) >> sh;
        return prod[31:0];
    endfunction

    // atan(2^-j) in units of 2^-32 turn
    function automatic logic [31:0] arc_turns(input int j);
        logic [63:0] t;
        logic [63:0] piece;
        logic [63:0] prod;
        int          d;
        if (j == 0) return 32'd1 << 29;
        t = 64'd0;
        for (int n = 0; j * (2 * n + 1) <= 60; n++) begin
            d     = 2 * n + 1;
            piece = (64'd1 << (60 - j * d)) / 64'(d);
            if ((n & 1) != 0) t = t - piece;
            else              t = t + piece;
        end
        prod = ((t >> 28) * INV_TWO_PI_Q32 + (64'd1 << 31)) >> 32;
        return prod[31:0];
    endfunction

endpackage

// ----- rtl/spe_phase.sv -----
// Frequency table lookup and phase multiply: two pipeline stages.
module spe_phase #(
    parameter int DIM = spe_pkg::DIM_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  spe_pkg::in_beat_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output spe_pkg::phase_beat_t out_data
);

    localparam int PAIR_SLOTS = 2 ** spe_pkg::PAIR_W;
    localparam int PAIRS      = DIM / 2;

    logic [31:0] freq_rom [PAIR_SLOTS];

    for (genvar g = 0; g < PAIR_SLOTS; g++) begin : g_freq
        localparam logic [63:0] EXP_Q32 = (64'(2 * g) * spe_pkg::LOG2_TENK_Q32) / 64'(DIM);
        localparam logic [31:0] FREQ    =
            (g < PAIRS) ? spe_pkg::pair_frequency(EXP_Q32) : 32'd0;
        assign freq_rom[g] = FREQ;
    end

    logic                       v1_reg;
    logic [spe_pkg::POS_W-1:0]  pos1_reg;
    logic [31:0]                freq1_reg;
    logic                       blank1_reg;
    logic                       blank1_next;
    logic                       v2_reg;
    spe_pkg::phase_beat_t       data2_reg;
    spe_pkg::phase_beat_t       data2_next;
    logic [31:0]                phase;
    logic                       en1;
    logic                       en2;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // pairs past the table have no columns: force a zero result
    assign blank1_next = int'(in_data.pair_index) >= PAIRS;

    assign phase = 32'(pos1_reg) * freq1_reg;

    always_comb begin
        data2_next.blank = blank1_reg;
        data2_next.quad  = spe_pkg::quad_t'(phase[31:30]);
        data2_next.resid = phase[spe_pkg::RESID_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            pos1_reg   <= in_data.position;
            freq1_reg  <= freq_rom[in_data.pair_index];
            blank1_reg <= blank1_next;
        end
        if (en2 && v1_reg) begin
            data2_reg <= data2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = data2_reg;

endmodule

// ----- rtl/spe_cordic.sv -----
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
module spe_cordic #(
    parameter int CORDIC_STEPS = spe_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  spe_pkg::phase_beat_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output spe_pkg::cordic_beat_t out_data
);

    localparam int CW = spe_pkg::CW;

    logic                  v_reg  [CORDIC_STEPS];
    spe_pkg::cordic_beat_t st_reg [CORDIC_STEPS];
    logic                  en     [CORDIC_STEPS+1];
    spe_pkg::cordic_beat_t init;

    always_comb begin
        init.blank = in_data.blank;
        init.quad  = in_data.quad;
        init.x     = spe_pkg::CORDIC_GAIN_Q30;
        init.y     = '0;
        init.z     = $signed(CW'(in_data.resid));
    end

    assign en[CORDIC_STEPS] = out_ready;
    assign in_ready         = en[0];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
        localparam logic [31:0]          ARC_U = spe_pkg::arc_turns(g);
        localparam logic signed [CW-1:0] ARC   = $signed(CW'(ARC_U));

        spe_pkg::cordic_beat_t src;
        spe_pkg::cordic_beat_t st_next;
        logic                  src_valid;
        logic signed [CW-1:0]  xs;
        logic signed [CW-1:0]  ys;
        logic signed [CW-1:0]  zs;

        if (g == 0) begin : g_first
            assign src       = init;
            assign src_valid = in_valid;
        end else begin : g_rest
            assign src       = st_reg[g-1];
            assign src_valid = v_reg[g-1];
        end

        // a stage may take a new beat when empty or when its beat moves on
        assign en[g] = !v_reg[g] || en[g+1];

        always_comb begin
            xs      = src.x;
            ys      = src.y;
            zs      = src.z;
            st_next = src;
            if (!zs[CW-1]) begin
                st_next.x = xs - (ys >>> g);
                st_next.y = ys + (xs >>> g);
                st_next.z = zs - ARC;
            end else begin
                st_next.x = xs + (ys >>> g);
                st_next.y = ys - (xs >>> g);
                st_next.z = zs + ARC;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en[g]) begin
                v_reg[g] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[g] && src_valid) begin
                st_reg[g] <= st_next;
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS-1];
    assign out_data  = st_reg[CORDIC_STEPS-1];

endmodule

// ----- rtl/spe_out.sv -----
// Quadrant fold, Q1.15 rounding with saturation, and the output register.
module spe_out (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  spe_pkg::cordic_beat_t in_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output spe_pkg::out_beat_t    m_data
);

    localparam int CW    = spe_pkg::CW;
    localparam int VAL_W = spe_pkg::VAL_W;

    function automatic logic signed [VAL_W-1:0] to_q15(input logic signed [CW:0] v);
        logic signed [CW:0]    biased;
        logic signed [CW-15:0] r;
        biased = v + $signed((CW+1)'(16384));
        r      = biased[CW:15];
        if (r > $signed((CW-14)'(32767)))       return 16'sh7FFF;
        else if (r < -$signed((CW-14)'(32768))) return 16'sh8000;
        else                                    return r[VAL_W-1:0];
    endfunction

    logic                 m_valid_reg;
    spe_pkg::out_beat_t   m_data_reg;
    spe_pkg::out_beat_t   m_data_next;
    logic signed [CW:0]   xe;
    logic signed [CW:0]   ye;
    logic signed [CW:0]   s;
    logic signed [CW:0]   c;

    assign in_ready = !m_valid_reg || m_ready;

    assign xe = (CW+1)'(in_data.x);
    assign ye = (CW+1)'(in_data.y);

    // rotate the first-quadrant result into the quadrant of the phase
    always_comb begin
        unique case (in_data.quad)
            spe_pkg::QUAD_0: begin s = ye;  c = xe;  end
            spe_pkg::QUAD_1: begin s = xe;  c = -ye; end
            spe_pkg::QUAD_2: begin s = -ye; c = -xe; end
            spe_pkg::QUAD_3: begin s = -xe; c = ye;  end
            default:         begin s = ye;  c = xe;  end
        endcase
    end

    always_comb begin
        if (in_data.blank) begin
            m_data_next.sin_value = '0;
            m_data_next.cos_value = '0;
        end else begin
            m_data_next.sin_value = to_q15(s);
            m_data_next.cos_value = to_q15(c);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/sinusoidal_position_encoder.sv -----
// Sinusoidal position encoder: one (sin, cos) pair per position and pair index.
// Each beat carries a position and a pair index and returns sin and cos of
// position / 10000^(2i/DIM) as Q1.15, with +1.0 saturated to 32767; pair
// indexes at or past DIM/2 return zero for both. The block is a fully
// pipelined datapath that takes one beat per clock unless back-pressure
// from the output stalls it: two stages look up the pair frequency and
// form the phase, CORDIC_STEPS stages each perform one CORDIC shift-add
// rotation, and one stage folds the quadrant and rounds. Every stage has
// its own valid bit, so a stalled output only holds back the stages behind
// it once they are full, and bubbles are squeezed out while the output waits.
module sinusoidal_position_encoder #(
    parameter int DIM          = spe_pkg::DIM_DEFAULT,
    parameter int CORDIC_STEPS = spe_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  spe_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output spe_pkg::out_beat_t m_data
);

    logic                  ph_valid;
    logic                  ph_ready;
    spe_pkg::phase_beat_t  ph_data;
    logic                  cd_valid;
    logic                  cd_ready;
    spe_pkg::cordic_beat_t cd_data;

    spe_phase #(
        .DIM (DIM)
    ) u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (ph_valid),
        .out_ready (ph_ready),
        .out_data  (ph_data)
    );

    spe_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .in_data   (ph_data),
        .out_valid (cd_valid),
        .out_ready (cd_ready),
        .out_data  (cd_data)
    );

    spe_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (cd_valid),
        .in_ready (cd_ready),
        .in_data  (cd_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- rtl/spe_checker.sv -----
// Port-level checks for the position encoder, bound to the top level.
module spe_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input spe_pkg::out_beat_t m_data
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // reset drains the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // with the output free to move, every stage can advance
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled while output is draining");

    // accepting an input beat while the output is stalled never drops the held result
    a_accept_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && m_valid && !m_ready |=> m_valid)
        else $error("result dropped while input was accepted");

endmodule

bind sinusoidal_position_encoder spe_checker u_spe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- dv/sinusoidal_position_encoder_test.sv -----
// Self-checking testbench for the sinusoidal position encoder: directed table, random beats, back-pressure.
module sinusoidal_position_encoder_test;

    localparam int ENC_DIM     = 128;
    localparam int ENC_STEPS   = 16;
    localparam int PIPE_DEPTH  = ENC_STEPS + 3;
    localparam int HOLD_LEN    = 200;
    localparam int WDOG_LIMIT  = 4000;
    localparam int DIRECTED_N  = 20;

    typedef struct packed {
        logic               on;
        logic signed [15:0] cos_q15;
    } cos_pin_t;

    typedef struct packed {
        logic [spe_pkg::POS_W-1:0]  position;
        logic [spe_pkg::PAIR_W-1:0] pair_index;
        logic                       pin_on;
        logic signed [15:0]         pin_cos;
    } directed_row_t;

    typedef struct packed {
        spe_pkg::in_beat_t  src;
        spe_pkg::out_beat_t want;
    } pending_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    spe_pkg::in_beat_t  s_data;
    logic               m_valid;
    logic               m_ready;
    spe_pkg::out_beat_t m_data;

    logic [31:0] pair_freq [ENC_DIM/2];
    longint      atan_step [ENC_STEPS];

    pending_t pending_pairs [$];
    cos_pin_t cos_pins [$];

    bit idle_on;
    bit stall_req;
    bit hold_done;
    int errors       = 0;
    int accepted     = 0;
    int results_seen = 0;
    int in_stalls    = 0;
    int quiet_cycles = 0;

    // Position zero gives phase zero: cosine is exactly one and saturates.
    directed_row_t plan [DIRECTED_N] = '{
        '{12'd0,    6'd0,  1'b1, 16'sd32767},
        '{12'd0,    6'd63, 1'b1, 16'sd32767},
        '{12'd0,    6'd31, 1'b1, 16'sd32767},
        '{12'd4095, 6'd0,  1'b0, 16'sd0},
        '{12'd4095, 6'd63, 1'b0, 16'sd0},
        '{12'd4095, 6'd31, 1'b0, 16'sd0},
        '{12'd1,    6'd0,  1'b0, 16'sd0},
        '{12'd2,    6'd0,  1'b0, 16'sd0},
        '{12'd3,    6'd0,  1'b0, 16'sd0},
        '{12'd4,    6'd0,  1'b0, 16'sd0},
        '{12'd5,    6'd0,  1'b0, 16'sd0},
        '{12'd6,    6'd0,  1'b0, 16'sd0},
        '{12'd7,    6'd0,  1'b0, 16'sd0},
        '{12'd4095, 6'd1,  1'b0, 16'sd0},
        '{12'd2048, 6'd32, 1'b0, 16'sd0},
        '{12'd1024, 6'd63, 1'b0, 16'sd0},
        '{12'd100,  6'd10, 1'b0, 16'sd0},
        '{12'd4000, 6'd5,  1'b0, 16'sd0},
        '{12'd2730, 6'd62, 1'b0, 16'sd0},
        '{12'd1,    6'd63, 1'b0, 16'sd0}
    };

    sinusoidal_position_encoder #(
        .DIM          (ENC_DIM),
        .CORDIC_STEPS (ENC_STEPS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Turns per position as UQ0.32 for pair i: 1 / (2 pi 10000^(2i/DIM))
    function automatic logic [31:0] freq_for_pair(input int i);
        logic [63:0] expo;
        logic [63:0] frac;
        logic [63:0] ln_frac;
        logic [63:0] term;
        logic [63:0] even_sum;
        logic [63:0] odd_sum;
        logic [63:0] mant;
        int          shift;
        expo     = (64'(2 * i) * spe_pkg::LOG2_TENK_Q32) / 64'(ENC_DIM);
        shift    = 32 + int'(expo >> 32);
        frac     = {32'd0, expo[31:0]};
        ln_frac  = (frac * spe_pkg::LN2_Q32) >> 32;
        term     = 64'd1 << 32;
        even_sum = term;
        odd_sum  = 64'd0;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * ln_frac) >> 32) / 64'(n);
            if (n % 2 == 1) odd_sum = odd_sum + term;
            else            even_sum = even_sum + term;
        end
        mant = even_sum - odd_sum;
        if (shift >= 63) return 32'd0;
        return 32'((mant * spe_pkg::INV_TWO_PI_Q32 + (64'd1 << (shift - 1))) >> shift);
    endfunction

    // atan(2^-j) in 2^-32 turn, from the arctan power series
    function automatic longint atan_for_step(input int j);
        longint      acc;
        logic [63:0] piece;
        int          d;
        if (j == 0) return longint'(1) << 29;
        acc = 0;
        for (int n = 0; j * (2 * n + 1) <= 60; n++) begin
            d     = 2 * n + 1;
            piece = (64'd1 << (60 - j * d)) / 64'(d);
            if (n % 2 == 1) acc = acc - longint'(piece);
            else            acc = acc + longint'(piece);
        end
        return longint'(((64'(acc) >> 28) * spe_pkg::INV_TWO_PI_Q32 + (64'd1 << 31)) >> 32);
    endfunction

    function automatic logic signed [15:0] round_q15(input longint v);
        longint r;
        r = (v + (longint'(1) << 14)) >>> 15;
        if (r > 32767)  r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    function automatic spe_pkg::out_beat_t encode_pair(input spe_pkg::in_beat_t beat);
        spe_pkg::out_beat_t res;
        logic [31:0]        phase;
        spe_pkg::quad_t     quad;
        longint             x;
        longint             y;
        longint             z;
        longint             dx;
        longint             dy;
        longint             s;
        longint             c;
        res = '0;
        if (int'(beat.pair_index) >= ENC_DIM / 2) return res;
        phase = 32'(64'(beat.position) * 64'(pair_freq[beat.pair_index]));
        quad  = spe_pkg::quad_t'(phase[31:30]);
        z     = longint'(phase[29:0]);
        x     = longint'(spe_pkg::CORDIC_GAIN_Q30);
        y     = 0;
        for (int j = 0; j < ENC_STEPS; j++) begin
            dx = y >>> j;
            dy = x >>> j;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step[j];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step[j];
            end
        end
        case (quad)
            spe_pkg::QUAD_0: begin s = y;  c = x;  end
            spe_pkg::QUAD_1: begin s = x;  c = -y; end
            spe_pkg::QUAD_2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
        res.sin_value = round_q15(s);
        res.cos_value = round_q15(c);
        return res;
    endfunction

    task automatic offer_beat(input spe_pkg::in_beat_t beat, input logic pin_on,
                              input logic signed [15:0] pin_cos);
        cos_pins.push_back(cos_pin_t'{pin_on, pin_cos});
        while (idle_on && $urandom_range(0, 99) < 10) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic offer_random(input int count);
        spe_pkg::in_beat_t beat;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0: beat.position = '0;
                1: beat.position = '1;
                2: beat.position = spe_pkg::POS_W'($urandom_range(0, 15));
                default: beat.position = spe_pkg::POS_W'($urandom_range(0, 4095));
            endcase
            beat.pair_index = spe_pkg::PAIR_W'($urandom_range(0, 63));
            offer_beat(beat, 1'b0, 16'sd0);
        end
    endtask

    // Receiver: random back-pressure, plus one long hold on request
    initial begin
        m_ready   = 1'b0;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (stall_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready <= (!idle_on || $urandom_range(0, 99) >= 10);
            end
        end
    end

    // Scoreboard: predict on input beats, compare output beats in order
    always @(posedge aclk) begin
        pending_t rec;
        cos_pin_t pin;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_pairs.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: sin %0d cos %0d", $time,
                             m_data.sin_value, m_data.cos_value);
                end else begin
                    rec = pending_pairs.pop_front();
                    results_seen++;
                    if (m_data.sin_value !== rec.want.sin_value) begin
                        errors++;
                        $display("%0t sin mismatch (pos %0d pair %0d): expected %0d, got %0d",
                                 $time, rec.src.position, rec.src.pair_index,
                                 rec.want.sin_value, m_data.sin_value);
                    end
                    if (m_data.cos_value !== rec.want.cos_value) begin
                        errors++;
                        $display("%0t cos mismatch (pos %0d pair %0d): expected %0d, got %0d",
                                 $time, rec.src.position, rec.src.pair_index,
                                 rec.want.cos_value, m_data.cos_value);
                    end
                end
            end
            if (s_valid && s_ready) begin
                rec.src  = s_data;
                rec.want = encode_pair(s_data);
                pin      = cos_pins.pop_front();
                if (pin.on) rec.want.cos_value = pin.cos_q15;
                pending_pairs.push_back(rec);
                accepted++;
            end
            if (s_valid && !s_ready) in_stalls++;
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("%0t watchdog: no beat moved in %0d cycles", $time, WDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        idle_on   = 1'b1;
        stall_req = 1'b0;
        for (int i = 0; i < ENC_DIM / 2; i++) pair_freq[i] = freq_for_pair(i);
        for (int j = 0; j < ENC_STEPS; j++) atan_step[j] = atan_for_step(j);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIRECTED_N; r++)
            offer_beat({plan[r].position, plan[r].pair_index}, plan[r].pin_on, plan[r].pin_cos);

        offer_random(600);
        // long stretch at full rate on both sides
        idle_on = 1'b0;
        offer_random(400);
        idle_on = 1'b1;
        // hold the output long enough to fill the pipeline and stall the input
        stall_req = 1'b1;
        offer_random(200);
        offer_random(600);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 8) @(posedge aclk);

        $display("Checked %0d results from %0d beats (%0d directed), all quadrants and pair indexes.",
                 results_seen, accepted, DIRECTED_N);
        $display("Input held off %0d cycles by back-pressure, including one %0d-cycle output hold.",
                 in_stalls, HOLD_LEN);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
